/* src/suuid_pkg.sv */
`timescale 1ns / 1ps

package suuid_pkg;

    // parse phases
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_FORMAT  = 3'd2;
    localparam logic [2:0] PH_STRINGS = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam int UUID_BYTES = 16;

    localparam logic [7:0] SYSINFO_TYPE   = 8'h01;
    localparam logic [7:0] SYSINFO_MINLEN = 8'h19;
    localparam logic [7:0] UUID_OFFSET    = 8'h08;
    localparam logic [7:0] UUID_LAST      = UUID_OFFSET + 8'(UUID_BYTES - 1);
    localparam logic [7:0] BYTE_ONES      = 8'hFF;
    localparam logic [7:0] MIN_LENGTH     = 8'd4;
    localparam logic [3:0] LAST_INDEX     = 4'(UUID_BYTES - 1);

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic capture;   // shift one raw UUID byte in
        logic launch;    // reorder to canonical order, first byte leaves
        logic advance;   // shift one canonical byte out
    } shift_ctl_t;

    // raw byte position feeding canonical position k
    function automatic logic [3:0] canon_src(input logic [3:0] k);
        logic [3:0] src;
        unique case (k)
            4'd0:    src = 4'd3;
            4'd1:    src = 4'd2;
            4'd2:    src = 4'd1;
            4'd3:    src = 4'd0;
            4'd4:    src = 4'd5;
            4'd5:    src = 4'd4;
            4'd6:    src = 4'd7;
            4'd7:    src = 4'd6;
            default: src = k;
        endcase
        return src;
    endfunction

endpackage

/* src/suuid_shifter.sv */
`timescale 1ns / 1ps

module suuid_shifter
(
    input  logic                   clk,
    input  suuid_pkg::byte_t       din,
    input  suuid_pkg::shift_ctl_t  ctl,
    output suuid_pkg::byte_t       first,
    output suuid_pkg::byte_t       head
);

    suuid_pkg::byte_t cap_reg  [suuid_pkg::UUID_BYTES];
    suuid_pkg::byte_t cap_next [suuid_pkg::UUID_BYTES];
    suuid_pkg::byte_t shifted  [suuid_pkg::UUID_BYTES];

    // raw order after taking din
    always_comb
    begin
        for (int k = 0; k < suuid_pkg::UUID_BYTES - 1; k++)
        begin
            shifted[k] = cap_reg[k + 1];
        end
        shifted[suuid_pkg::UUID_BYTES - 1] = din;
    end

    assign first = shifted[suuid_pkg::canon_src(4'd0)];
    assign head  = cap_reg[0];

    always_comb
    begin
        for (int k = 0; k < suuid_pkg::UUID_BYTES; k++)
        begin
            cap_next[k] = cap_reg[k];
        end
        priority if (ctl.launch)
        begin
            for (int k = 0; k < suuid_pkg::UUID_BYTES - 1; k++)
            begin
                cap_next[k] = shifted[suuid_pkg::canon_src(4'(k + 1))];
            end
        end
        else if (ctl.capture)
        begin
            for (int k = 0; k < suuid_pkg::UUID_BYTES; k++)
            begin
                cap_next[k] = shifted[k];
            end
        end
        else if (ctl.advance)
        begin
            for (int k = 0; k < suuid_pkg::UUID_BYTES - 1; k++)
            begin
                cap_next[k] = cap_reg[k + 1];
            end
        end
        else
        begin
            // hold
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < suuid_pkg::UUID_BYTES; k++)
        begin
            cap_reg[k] <= cap_next[k];
        end
    end

endmodule

/* src/smbios_uuid_extractor.sv */
`timescale 1ns / 1ps

// Channel   Handshake                  Beat payload
// table     table_valid / table_ready  table_byte, final_byte
// uuid      uuid_valid  / uuid_ready   uuid_byte, byte_index, found, last_result
//
// One table byte is taken per cycle while no report is being sent.
// A UUID report is 16 beats out of one output register; the byte that
// completes the UUID loads beat 0 and table_ready stays low until the
// shift register has moved out the other 15 (one per free output cycle).
// A stalled output register (uuid_valid high, uuid_ready low) holds off input.
// Reset (rst_n low, async) returns the parser to the type-byte phase and
// empties the output register; the UUID shift register is not reset.

module smbios_uuid_extractor
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] table_byte,
    input  logic       final_byte,
    input  logic       table_valid,
    output logic       table_ready,
    output logic [7:0] uuid_byte,
    output logic [3:0] byte_index,
    output logic       found,
    output logic       last_result,
    output logic       uuid_valid,
    input  logic       uuid_ready
);

    // parser state
    logic [2:0] phase_reg, phase_next;
    logic [7:0] kind_reg, kind_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] pos_reg, pos_next;
    logic       prevz_reg, prevz_next;
    logic       nz_reg, nz_next;
    logic       nff_reg, nff_next;

    // report sequencing
    logic       emit_reg;
    logic [3:0] eidx_reg;

    // output register
    logic       ovalid_reg;
    logic [7:0] obyte_reg;
    logic [3:0] oidx_reg;
    logic       ofound_reg;
    logic       olast_reg;

    logic       accept;
    logic       out_free;
    logic       fail;
    logic       succ;
    logic       capture;
    logic       was_done;
    logic [7:0] pos_inc;
    logic       in_win;

    suuid_pkg::shift_ctl_t ctl;
    suuid_pkg::byte_t      first_byte;
    suuid_pkg::byte_t      head_byte;

    assign out_free    = !ovalid_reg || uuid_ready;
    assign table_ready = !emit_reg && out_free;
    assign accept      = table_valid && table_ready;

    assign was_done = (phase_reg != suuid_pkg::PH_TYPE) && (phase_reg != suuid_pkg::PH_LENGTH)
                   && (phase_reg != suuid_pkg::PH_FORMAT) && (phase_reg != suuid_pkg::PH_STRINGS);

    assign pos_inc = pos_reg + 8'd1;
    assign in_win  = (kind_reg == suuid_pkg::SYSINFO_TYPE) && (len_reg >= suuid_pkg::SYSINFO_MINLEN)
                  && (pos_inc >= suuid_pkg::UUID_OFFSET) && (pos_inc <= suuid_pkg::UUID_LAST);

    // structure walk, one byte per beat
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        prevz_next = prevz_reg;
        nz_next    = nz_reg;
        nff_next   = nff_reg;
        fail       = 1'b0;
        succ       = 1'b0;
        capture    = 1'b0;

        unique case (phase_reg)
            suuid_pkg::PH_TYPE:
            begin
                kind_next  = table_byte;
                pos_next   = 8'd0;
                phase_next = suuid_pkg::PH_LENGTH;
            end
            suuid_pkg::PH_LENGTH:
            begin
                len_next = table_byte;
                pos_next = 8'd1;
                nz_next  = 1'b0;
                nff_next = 1'b0;
                if (table_byte < suuid_pkg::MIN_LENGTH)
                begin
                    fail       = 1'b1;
                    phase_next = suuid_pkg::PH_DONE;
                end
                else
                begin
                    phase_next = suuid_pkg::PH_FORMAT;
                end
            end
            suuid_pkg::PH_FORMAT:
            begin
                pos_next = pos_inc;
                if (in_win)
                begin
                    capture  = 1'b1;
                    nz_next  = nz_reg || (table_byte != 8'h00);
                    nff_next = nff_reg || (table_byte != suuid_pkg::BYTE_ONES);
                    if (pos_inc == suuid_pkg::UUID_LAST)
                    begin
                        phase_next = suuid_pkg::PH_DONE;
                        if (nz_next && nff_next)
                        begin
                            succ = 1'b1;
                        end
                        else
                        begin
                            fail = 1'b1;
                        end
                    end
                end
                else if (({1'b0, pos_inc} + 9'd1) >= {1'b0, len_reg})
                begin
                    phase_next = suuid_pkg::PH_STRINGS;
                    prevz_next = 1'b0;
                end
            end
            suuid_pkg::PH_STRINGS:
            begin
                if (prevz_reg && (table_byte == 8'h00))
                begin
                    phase_next = suuid_pkg::PH_TYPE;
                    prevz_next = 1'b0;
                end
                else
                begin
                    prevz_next = (table_byte == 8'h00);
                end
            end
            default:
            begin
                // report made: skip until the final byte
            end
        endcase

        if (final_byte)
        begin
            if (!was_done && !fail && !succ)
            begin
                fail = 1'b1;
            end
            phase_next = suuid_pkg::PH_TYPE;
            kind_next  = 8'd0;
            len_next   = 8'd0;
            pos_next   = 8'd0;
            prevz_next = 1'b0;
            nz_next    = 1'b0;
            nff_next   = 1'b0;
        end
    end

    assign ctl.capture = accept && capture;
    assign ctl.launch  = accept && succ;
    assign ctl.advance = emit_reg && out_free;

    suuid_shifter u_shifter
    (
        .clk   (clk),
        .din   (table_byte),
        .ctl   (ctl),
        .first (first_byte),
        .head  (head_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= suuid_pkg::PH_TYPE;
            kind_reg   <= 8'd0;
            len_reg    <= 8'd0;
            pos_reg    <= 8'd0;
            prevz_reg  <= 1'b0;
            nz_reg     <= 1'b0;
            nff_reg    <= 1'b0;
            emit_reg   <= 1'b0;
            eidx_reg   <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                len_reg   <= len_next;
                pos_reg   <= pos_next;
                prevz_reg <= prevz_next;
                nz_reg    <= nz_next;
                nff_reg   <= nff_next;
            end

            priority if (accept && (fail || succ))
            begin
                ovalid_reg <= 1'b1;
                if (succ)
                begin
                    emit_reg <= 1'b1;
                    eidx_reg <= 4'd1;
                end
            end
            else if (emit_reg && out_free)
            begin
                ovalid_reg <= 1'b1;
                eidx_reg   <= eidx_reg + 4'd1;
                if (eidx_reg == suuid_pkg::LAST_INDEX)
                begin
                    emit_reg <= 1'b0;
                end
            end
            else if (uuid_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            else
            begin
                // beat held for the receiver
            end
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        priority if (accept && fail)
        begin
            obyte_reg  <= 8'd0;
            oidx_reg   <= 4'd0;
            ofound_reg <= 1'b0;
            olast_reg  <= 1'b1;
        end
        else if (accept && succ)
        begin
            obyte_reg  <= first_byte;
            oidx_reg   <= 4'd0;
            ofound_reg <= 1'b1;
            olast_reg  <= 1'b0;
        end
        else if (emit_reg && out_free)
        begin
            obyte_reg  <= head_byte;
            oidx_reg   <= eidx_reg;
            ofound_reg <= 1'b1;
            olast_reg  <= (eidx_reg == suuid_pkg::LAST_INDEX);
        end
        else
        begin
            // hold
        end
    end

    assign uuid_valid  = ovalid_reg;
    assign uuid_byte   = obyte_reg;
    assign byte_index  = oidx_reg;
    assign found       = ofound_reg;
    assign last_result = olast_reg;

    // a failure beat is a lone all-zero beat
    a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
        uuid_valid && !found |-> last_result && (uuid_byte == 8'd0) && (byte_index == 4'd0))
        else $error("failure beat malformed");

    // a success report closes on index 15
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        uuid_valid && found && last_result |-> (byte_index == suuid_pkg::LAST_INDEX))
        else $error("success report closed early");

    // success beats follow back to back with rising index
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        uuid_valid && uuid_ready && found && !last_result
        |=> uuid_valid && found && (byte_index == 4'($past(byte_index) + 4'd1)))
        else $error("uuid beat sequence broken");

    // no table byte taken while a report is in flight
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        uuid_valid && found && !last_result |-> !table_ready)
        else $error("input taken during report");

endmodule
